/* src/ifp_pkg.sv */
// shared types, constants and group table for the inertial frame parser
// no dependencies
`timescale 1ns / 1ps

package ifp_pkg;

  // capture store geometry
  localparam int CAPTURE_DEPTH = 128;
  localparam int AW            = $clog2(CAPTURE_DEPTH);

  // frame framing bytes
  localparam logic [7:0] PREAMBLE       = 8'hFA;
  localparam logic [7:0] BUS_ID         = 8'hFF;
  localparam logic [7:0] EXT_LEN_MARK   = 8'hFF;
  localparam logic [7:0] MSG_ID_RESET   = 8'h36;

  // register map
  localparam logic REG_DECODE_MSG_ID = 1'b0;

  // group codes
  localparam logic [2:0] GRP_EULER  = 3'd0;
  localparam logic [2:0] GRP_ACCEL  = 3'd1;
  localparam logic [2:0] GRP_RATE   = 3'd2;
  localparam logic [2:0] GRP_LATLON = 3'd3;
  localparam logic [2:0] GRP_ALT    = 3'd4;
  localparam logic [2:0] GRP_VEL    = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_BUS,
    PH_MSGID,
    PH_LEN,
    PH_EXTLEN,
    PH_DATA,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    X_IDLE,
    X_READ,
    X_LAST,
    X_PUSH
  } xstate_e;

  // store write port
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } ifp_wr_t;

  // extractor status seen by the parser
  typedef struct packed {
    logic          busy;
    logic [AW-1:0] next_addr;
  } ifp_xstat_t;

  function automatic logic [AW-1:0] grp_offset(input logic [2:0] g);
    logic [AW-1:0] r;
    case (g)
      GRP_EULER:  r = AW'(4);
      GRP_ACCEL:  r = AW'(19);
      GRP_RATE:   r = AW'(34);
      GRP_LATLON: r = AW'(49);
      GRP_ALT:    r = AW'(60);
      GRP_VEL:    r = AW'(67);
      default:    r = '0;
    endcase
    return r;
  endfunction

  // index of the last byte read for a group: two id bytes plus four per word
  function automatic logic [3:0] grp_last(input logic [2:0] g);
    logic [3:0] r;
    case (g)
      GRP_LATLON: r = 4'd9;
      GRP_ALT:    r = 4'd5;
      default:    r = 4'd13;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] grp_id(input logic [2:0] g);
    logic [15:0] r;
    case (g)
      GRP_EULER:  r = 16'h2030;
      GRP_ACCEL:  r = 16'h4020;
      GRP_RATE:   r = 16'h8020;
      GRP_LATLON: r = 16'h5040;
      GRP_ALT:    r = 16'h5020;
      GRP_VEL:    r = 16'hD010;
      default:    r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

/* src/ifp_store.sv */
// byte-wide capture store, one write and one registered read per cycle
// depends on ifp_pkg; per-entry valid bits make unwritten entries read as zero
`timescale 1ns / 1ps

module ifp_store import ifp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ifp_wr_t       wr_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0]               mem [CAPTURE_DEPTH];
  logic [CAPTURE_DEPTH-1:0] vld_q;
  logic [7:0]               rdata_q;
  logic                     rvld_q;

  // read returns the value held before a write at the same edge
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : 8'h00;

endmodule

/* src/ifp_extract.sv */
// group extractor: walks the store byte by byte and builds six results
// depends on ifp_pkg; reads through ifp_store's single read port
`timescale 1ns / 1ps

module ifp_extract import ifp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output ifp_xstat_t    xstat_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    group_code_o,
  output logic          present_o,
  output logic [31:0]   word_a_o,
  output logic [31:0]   word_b_o,
  output logic [31:0]   word_c_o,
  output logic          last_o
);

  xstate_e     xs_q, xs_d;
  logic [2:0]  grp_q, grp_d;
  logic [3:0]  k_q, k_d;
  logic [3:0]  sl_q;
  logic        sl_v_q;
  logic [7:0]  id_hi_q, id_hi_d, id_lo_q, id_lo_d;
  logic [95:0] acc_q, acc_d;
  logic        hit;

  logic        ov_q, ov_d;
  logic [2:0]  code_q, code_d;
  logic        pres_q, pres_d;
  logic [31:0] wa_q, wa_d, wb_q, wb_d, wc_q, wc_d;
  logic        last_q, last_d;

  // skip the byte between the data id and the first word
  assign rd_addr_o = grp_offset(grp_q) + AW'(k_q) + AW'(k_q >= 4'd2);

  assign xstat_o.busy      = (xs_q != X_IDLE);
  assign xstat_o.next_addr = rd_addr_o;

  assign hit = ({id_hi_q, id_lo_q} == grp_id(grp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q   <= X_IDLE;
      grp_q  <= '0;
      k_q    <= '0;
      sl_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      xs_q   <= xs_d;
      grp_q  <= grp_d;
      k_q    <= k_d;
      sl_v_q <= (xs_q == X_READ);
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sl_q    <= k_q;
    id_hi_q <= id_hi_d;
    id_lo_q <= id_lo_d;
    acc_q   <= acc_d;
    code_q  <= code_d;
    pres_q  <= pres_d;
    wa_q    <= wa_d;
    wb_q    <= wb_d;
    wc_q    <= wc_d;
    last_q  <= last_d;
  end

  always_comb begin
    xs_d    = xs_q;
    grp_d   = grp_q;
    k_d     = k_q;
    id_hi_d = id_hi_q;
    id_lo_d = id_lo_q;
    acc_d   = acc_q;
    ov_d    = ov_q;
    code_d  = code_q;
    pres_d  = pres_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    wc_d    = wc_q;
    last_d  = last_q;

    // place the byte read in the previous cycle
    if (sl_v_q) begin
      if (sl_q == 4'd0) begin
        id_hi_d = rd_data_i;
      end else if (sl_q == 4'd1) begin
        id_lo_d = rd_data_i;
      end else begin
        for (int i = 0; i < 12; i++) begin
          if (sl_q == 4'(i + 2)) begin
            acc_d[95 - 8*i -: 8] = rd_data_i;
          end
        end
      end
    end

    if (out_ready_i) begin
      ov_d = 1'b0;
    end

    case (xs_q)
      X_IDLE: begin
        if (start_i) begin
          grp_d = GRP_EULER;
          k_d   = '0;
          acc_d = '0;
          xs_d  = X_READ;
        end
      end
      X_READ: begin
        if (k_q == grp_last(grp_q)) begin
          k_d  = '0;
          xs_d = X_LAST;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      X_LAST: begin
        xs_d = X_PUSH;
      end
      X_PUSH: begin
        if (!ov_q || out_ready_i) begin
          ov_d   = 1'b1;
          code_d = grp_q;
          pres_d = hit;
          wa_d   = hit ? acc_q[95:64] : 32'h0;
          wb_d   = hit ? acc_q[63:32] : 32'h0;
          wc_d   = hit ? acc_q[31:0]  : 32'h0;
          last_d = (grp_q == GRP_VEL);
          acc_d  = '0;
          if (grp_q == GRP_VEL) begin
            xs_d = X_IDLE;
          end else begin
            grp_d = grp_q + 3'd1;
            xs_d  = X_READ;
          end
        end
      end
      default: begin
        xs_d = X_IDLE;
      end
    endcase
  end

  assign out_valid_o  = ov_q;
  assign group_code_o = code_q;
  assign present_o    = pres_q;
  assign word_a_o     = wa_q;
  assign word_b_o     = wb_q;
  assign word_c_o     = wc_q;
  assign last_o       = last_q;

endmodule

/* src/inertial_frame_parser.sv */
// inertial frame parser: one received byte per cycle, six results per decoded frame
// throughput: one byte a cycle; a byte waits while its store write would hit an entry
// the burst still has to read, and a checksum waits until the previous burst is done
// reset: control state clears, id register loads 0x36 at once; unwritten store entries read 0
// depends on ifp_pkg, ifp_store and ifp_extract
`timescale 1ns / 1ps

module inertial_frame_parser import ifp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  group_code_o,
  output logic        present_o,
  output logic [31:0] word_a_o,
  output logic [31:0] word_b_o,
  output logic [31:0] word_c_o,
  output logic        last_o
);

  logic [7:0]    msg_id_q;
  phase_e        phase_q, phase_d;
  logic [15:0]   byte_index_q, byte_index_d;
  logic [15:0]   bytes_left_q, bytes_left_d;
  logic [7:0]    frame_id_q, frame_id_d;
  logic [15:0]   idx_inc;
  logic [15:0]   ext_len;
  logic          in_fire;
  logic          cap_en;
  logic          start;
  ifp_wr_t       wr;
  ifp_xstat_t    xstat;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DECODE_MSG_ID) ? {24'h0, msg_id_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_id_q <= MSG_ID_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DECODE_MSG_ID)) begin
      msg_id_q <= pwdata[7:0];
    end
  end

  // hold a byte back while the extractor still has to read its target entry, and a checksum byte while it is busy
  assign in_ready_o = !(xstat.busy && ((phase_q == PH_CHECK) ||
                        ((phase_q != PH_HUNT) && (byte_index_q >= 16'(xstat.next_addr)))));
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_inc = (byte_index_q == 16'hFFFF) ? byte_index_q : byte_index_q + 16'd1;
  assign ext_len = {bytes_left_q[7:0], rx_byte_i};

  always_comb begin
    phase_d      = phase_q;
    byte_index_d = byte_index_q;
    bytes_left_d = bytes_left_q;
    frame_id_d   = frame_id_q;
    cap_en       = 1'b0;
    start        = 1'b0;
    if (in_fire) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == PREAMBLE) begin
            cap_en       = 1'b1;
            byte_index_d = 16'd1;
            phase_d      = PH_BUS;
          end
        end
        PH_BUS: begin
          if (rx_byte_i != BUS_ID) begin
            byte_index_d = '0;
            phase_d      = PH_HUNT;
          end else begin
            cap_en       = 1'b1;
            byte_index_d = idx_inc;
            phase_d      = PH_MSGID;
          end
        end
        PH_MSGID: begin
          cap_en       = 1'b1;
          byte_index_d = idx_inc;
          frame_id_d   = rx_byte_i;
          phase_d      = PH_LEN;
        end
        PH_LEN: begin
          cap_en       = 1'b1;
          byte_index_d = idx_inc;
          if (rx_byte_i == EXT_LEN_MARK) begin
            phase_d = PH_EXTLEN;
          end else begin
            bytes_left_d = {8'h00, rx_byte_i};
            phase_d      = (rx_byte_i == 8'h00) ? PH_CHECK : PH_DATA;
          end
        end
        PH_EXTLEN: begin
          // big-endian length: first byte parks in the low half, second completes it
          cap_en       = 1'b1;
          byte_index_d = idx_inc;
          bytes_left_d = ext_len;
          if (idx_inc >= 16'd6) begin
            phase_d = (ext_len == 16'h0000) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          cap_en       = 1'b1;
          byte_index_d = idx_inc;
          bytes_left_d = bytes_left_q - 16'd1;
          if (bytes_left_q == 16'd1) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // checksum byte itself is neither stored nor checked
          start        = (frame_id_q == msg_id_q);
          byte_index_d = '0;
          frame_id_d   = '0;
          phase_d      = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      byte_index_q <= '0;
      bytes_left_q <= '0;
      frame_id_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_index_q <= byte_index_d;
      bytes_left_q <= bytes_left_d;
      frame_id_q   <= frame_id_d;
    end
  end

  assign wr.addr = (phase_q == PH_HUNT) ? '0 : byte_index_q[AW-1:0];
  assign wr.data = rx_byte_i;
  assign wr.en   = cap_en && ((phase_q == PH_HUNT) || (32'(byte_index_q) < CAPTURE_DEPTH));

  ifp_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ifp_extract u_extract (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .xstat_o      (xstat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .group_code_o (group_code_o),
    .present_o    (present_o),
    .word_a_o     (word_a_o),
    .word_b_o     (word_b_o),
    .word_c_o     (word_c_o),
    .last_o       (last_o)
  );

endmodule

/* src/ifp_checker.sv */
// port-level checks on the result channel of the inertial frame parser
// depends on ifp_pkg; bound to inertial_frame_parser below
`timescale 1ns / 1ps

module ifp_checker import ifp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  group_code_o,
  input logic        present_o,
  input logic [31:0] word_a_o,
  input logic [31:0] word_b_o,
  input logic [31:0] word_c_o,
  input logic        last_o
);

  logic [2:0] exp_q;

  // group expected next within a burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= GRP_EULER;
    end else if (out_valid_o && out_ready_i) begin
      exp_q <= last_o ? GRP_EULER : group_code_o + 3'd1;
    end
  end

  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> group_code_o == exp_q)
    else $error("result group out of order");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (group_code_o == GRP_VEL)))
    else $error("last flag not on final group");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !present_o) |-> (word_a_o == 32'h0 && word_b_o == 32'h0 &&
                                     word_c_o == 32'h0))
    else $error("absent group carries data");

  a_short_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (group_code_o == GRP_ALT || group_code_o == GRP_LATLON)) |->
      (word_c_o == 32'h0 && (group_code_o == GRP_LATLON || word_b_o == 32'h0)))
    else $error("unused word not zero");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(group_code_o) &&
                                      $stable(word_a_o)))
    else $error("stalled result changed");

endmodule

bind inertial_frame_parser ifp_checker u_ifp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .group_code_o (group_code_o),
  .present_o    (present_o),
  .word_a_o     (word_a_o),
  .word_b_o     (word_b_o),
  .word_c_o     (word_c_o),
  .last_o       (last_o)
);

/* sim/testbench.sv */
// self-checking testbench for inertial_frame_parser: byte stream in, group result transactions out
// keeps its own shadow of the parser state to predict every decoded frame
// depends on ifp_pkg and the inertial_frame_parser rtl
`timescale 1ns / 1ps

module testbench;
  import ifp_pkg::*;

  localparam logic [2:0] ADDR_DECODE_ID = 3'(REG_DECODE_MSG_ID) << 2;
  localparam logic [2:0] ADDR_SPARE     = ADDR_DECODE_ID + 3'd4;
  localparam int GROUP_COUNT   = 6;
  localparam int IDLE_PERCENT  = 7;
  localparam int SETTLE_CYCLES = 100;
  localparam int FRAME_WHOLE   = 1 << 30;
  localparam int EXT_LEN_POS   = 4;
  localparam int DATA_POS      = 4;
  localparam int EXT_DATA_POS  = 6;

  typedef struct packed {
    logic [2:0]  code;
    logic        present;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic        is_last;
  } group_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  group_code_o;
  logic        present_o;
  logic [31:0] word_a_o;
  logic [31:0] word_b_o;
  logic [31:0] word_c_o;
  logic        last_o;

  // shadow of the parser
  phase_e      frame_phase = PH_HUNT;
  logic [15:0] frame_pos = '0;
  logic [15:0] data_left = '0;
  logic [7:0]  frame_msg_id = '0;
  logic [7:0]  decode_id = MSG_ID_RESET;
  logic [7:0]  shadow_store [CAPTURE_DEPTH];

  group_result_t expected_groups [$];
  logic [7:0]    pending_bytes [$];
  int            bytes_queued = 0;
  int            bytes_accepted = 0;
  int            mismatch_count = 0;
  bit            calm = 1'b0;

  inertial_frame_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .group_code_o (group_code_o),
    .present_o    (present_o),
    .word_a_o     (word_a_o),
    .word_b_o     (word_b_o),
    .word_c_o     (word_c_o),
    .last_o       (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void group_layout(input logic [2:0] g, output int ofs,
                                       output logic [15:0] gid, output int nwords);
    case (g)
      GRP_EULER: begin
        ofs = 4; gid = 16'h2030; nwords = 3;
      end
      GRP_ACCEL: begin
        ofs = 19; gid = 16'h4020; nwords = 3;
      end
      GRP_RATE: begin
        ofs = 34; gid = 16'h8020; nwords = 3;
      end
      GRP_LATLON: begin
        ofs = 49; gid = 16'h5040; nwords = 2;
      end
      GRP_ALT: begin
        ofs = 60; gid = 16'h5020; nwords = 1;
      end
      default: begin
        // velocity
        ofs = 67; gid = 16'hD010; nwords = 3;
      end
    endcase
  endfunction

  function automatic logic [31:0] stored_word(input int pos);
    return {shadow_store[pos], shadow_store[pos + 1], shadow_store[pos + 2],
            shadow_store[pos + 3]};
  endfunction

  function automatic void emit_groups();
    group_result_t r;
    int ofs;
    int nwords;
    logic [15:0] gid;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      group_layout(3'(g), ofs, gid, nwords);
      r = '0;
      r.code = 3'(g);
      r.is_last = (g == GROUP_COUNT - 1);
      if ({shadow_store[ofs], shadow_store[ofs + 1]} == gid) begin
        r.present = 1'b1;
        r.word_a = stored_word(ofs + 3);
        if (nwords > 1) r.word_b = stored_word(ofs + 7);
        if (nwords > 2) r.word_c = stored_word(ofs + 11);
      end
      expected_groups.push_back(r);
    end
  endfunction

  function automatic void capture_byte(input logic [7:0] b);
    if (frame_pos < CAPTURE_DEPTH) shadow_store[frame_pos] = b;
    if (frame_pos != 16'hFFFF) frame_pos = frame_pos + 16'd1;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (frame_phase)
      PH_HUNT: begin
        if (b == PREAMBLE) begin
          frame_pos = '0;
          capture_byte(b);
          frame_phase = PH_BUS;
        end
      end
      PH_BUS: begin
        // a bad bus id is dropped, not retried as a preamble
        if (b != BUS_ID) begin
          frame_phase = PH_HUNT;
          frame_pos = '0;
        end else begin
          capture_byte(b);
          frame_phase = PH_MSGID;
        end
      end
      PH_MSGID: begin
        capture_byte(b);
        frame_msg_id = b;
        frame_phase = PH_LEN;
      end
      PH_LEN: begin
        capture_byte(b);
        if (b == EXT_LEN_MARK) begin
          frame_phase = PH_EXTLEN;
        end else begin
          data_left = {8'h00, b};
          if (data_left == 16'd0) frame_phase = PH_CHECK;
          else frame_phase = PH_DATA;
        end
      end
      PH_EXTLEN: begin
        capture_byte(b);
        if (frame_pos >= EXT_DATA_POS) begin
          data_left = {shadow_store[EXT_LEN_POS], shadow_store[EXT_LEN_POS + 1]};
          if (data_left == 16'd0) frame_phase = PH_CHECK;
          else frame_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        capture_byte(b);
        data_left = data_left - 16'd1;
        if (data_left == 16'd0) frame_phase = PH_CHECK;
      end
      PH_CHECK: begin
        // checksum byte is neither stored nor verified
        if (frame_msg_id == decode_id) emit_groups();
        frame_pos = '0;
        frame_msg_id = '0;
        frame_phase = PH_HUNT;
      end
      default: frame_phase = PH_HUNT;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_rx_byte(rx_byte_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    group_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_groups.size() == 0) begin
        $error("unexpected result transaction, group_code %0d", group_code_o);
        mismatch_count++;
      end else begin
        want = expected_groups.pop_front();
        check_field("group_code", 32'(want.code), 32'(group_code_o));
        check_field("present", 32'(want.present), 32'(present_o));
        check_field("word_a", want.word_a, word_a_o);
        check_field("word_b", want.word_b, word_b_o);
        check_field("word_c", want.word_c, word_c_o);
        check_field("last", 32'(want.is_last), 32'(last_o));
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_DECODE_MSG_ID) decode_id = data[7:0];
  endtask

  task automatic check_decode_id();
    logic [31:0] got;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DECODE_ID;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("decode_msg_id", {24'h0, decode_id}, got);
  endtask

  task automatic send_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // tags: groups whose data id is written; broken: of those, ids with a wrong low byte
  task automatic add_frame(input logic [7:0] id, input int len, input bit ext,
                           input logic [5:0] tags, input logic [5:0] broken, input int keep);
    logic [7:0] image [$];
    logic [7:0] b;
    logic [15:0] gid;
    int first;
    int ofs;
    int nwords;
    image.push_back(PREAMBLE);
    image.push_back(BUS_ID);
    image.push_back(id);
    if (ext) begin
      image.push_back(EXT_LEN_MARK);
      image.push_back(len[15:8]);
      image.push_back(len[7:0]);
      first = EXT_DATA_POS;
    end else begin
      image.push_back(len[7:0]);
      first = DATA_POS;
    end
    for (int p = first; p < first + len; p++) begin
      b = 8'($urandom);
      if (p < CAPTURE_DEPTH) begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
          group_layout(3'(g), ofs, gid, nwords);
          if (tags[g] && p == ofs) b = gid[15:8];
          if (tags[g] && p == ofs + 1) b = broken[g] ? ~gid[7:0] : gid[7:0];
        end
      end
      image.push_back(b);
    end
    image.push_back(8'($urandom));
    for (int i = 0; i < image.size() && i < keep; i++) send_byte(image[i]);
  endtask

  task automatic add_random_frame(output bit decoded);
    int kind;
    int len;
    int keep;
    bit ext;
    logic [7:0] id;
    kind = $urandom_range(99);
    id = ($urandom_range(99) < 75) ? decode_id : 8'($urandom);
    ext = 1'b0;
    if (kind < 45) len = $urandom_range(6, 0);
    else if (kind < 75) len = $urandom_range(16, 7);
    else if (kind < 90) begin
      ext = 1'b1;
      len = $urandom_range(8, 0);
    end else len = $urandom_range(24, 17);
    // line noise and broken starts between frames
    if ($urandom_range(99) < 10) repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    if ($urandom_range(99) < 5) begin
      send_byte(PREAMBLE);
      send_byte(8'($urandom_range(254, 0)));
    end
    keep = ($urandom_range(99) < 6) ? $urandom_range(len + 4, 1) : FRAME_WHOLE;
    add_frame(id, len, ext, 6'($urandom), 6'($urandom) & 6'($urandom), keep);
    decoded = (id == decode_id) && (keep == FRAME_WHOLE);
  endtask

  task automatic random_phase(input int min_bytes);
    int start;
    int decoded_frames;
    bit d;
    start = bytes_queued;
    decoded_frames = 0;
    while (bytes_queued - start < min_bytes || decoded_frames < 1) begin
      add_random_frame(d);
      decoded_frames += d;
    end
  endtask

  // sender holds until every queued byte is in and every group has come out
  task automatic drain();
    while (bytes_accepted != bytes_queued || expected_groups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < CAPTURE_DEPTH; i++) shadow_store[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_decode_id();

    // stray bytes while hunting, then a preamble whose bus id is another preamble
    send_byte(8'h00);
    send_byte(BUS_ID);
    send_byte(PREAMBLE);
    send_byte(PREAMBLE);
    send_byte(BUS_ID);
    send_byte(MSG_ID_RESET);
    send_byte(8'h00);
    send_byte(8'h5A);
    // empty frame, then one with every group tagged that runs past the end of the store
    add_frame(MSG_ID_RESET, 0, 1'b0, 6'h00, 6'h00, FRAME_WHOLE);
    add_frame(MSG_ID_RESET, 126, 1'b0, 6'h3F, 6'h00, FRAME_WHOLE);
    // extended length overwrites the euler id, other groups keep older bytes
    add_frame(MSG_ID_RESET, 2, 1'b1, 6'h00, 6'h00, FRAME_WHOLE);
    add_frame(MSG_ID_RESET, 0, 1'b1, 6'h00, 6'h00, FRAME_WHOLE);
    add_frame(MSG_ID_RESET, 2, 1'b0, 6'h01, 6'h01, FRAME_WHOLE);
    drain();

    reg_write(ADDR_DECODE_ID, {24'($urandom), 8'h00});
    check_decode_id();
    random_phase(6);
    drain();

    calm = 1'b1;
    reg_write(ADDR_DECODE_ID, {24'($urandom), 8'hFF});
    check_decode_id();
    random_phase(6);
    drain();
    calm = 1'b0;

    // a write to the unmapped slot must leave the id alone
    reg_write(ADDR_DECODE_ID, {24'($urandom), MSG_ID_RESET});
    reg_write(ADDR_SPARE, $urandom);
    check_decode_id();
    random_phase(6);
    drain();

    if (mismatch_count == 0) begin
      $display("inertial_frame_parser regression: pass");
    end else begin
      $display("inertial_frame_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("inertial_frame_parser regression: fail");
    $finish;
  end

endmodule
